>>> rtl/servo_bus_status_frame_parser_core_assert.svh
// Assertion macros shared by the servo bus status frame parser RTL.
`ifndef SERVO_BUS_STATUS_FRAME_PARSER_CORE_ASSERT_SVH
`define SERVO_BUS_STATUS_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsp assertion failed");

`endif

>>> rtl/sbsp_pkg.sv
// Package with the types and constants of the servo bus status frame parser.
package sbsp_pkg;

    localparam int MAX_PARAMS = 48;
    localparam int BYTE_W     = 8;
    localparam int PAR_W      = 6;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0] HDR_BYTE       = 8'hFF;
    localparam logic [BYTE_W-1:0] SCAN_MAX       = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_LENGTH     = 8'd2;
    localparam logic [BYTE_W-1:0] MAX_FRAME_LEN  = BYTE_W'(MAX_PARAMS + 2);
    localparam logic [BYTE_W-1:0] SCAN_LIMIT_RST = 8'd50;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 6'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOHDR  = 2'd1,
        ST_BADLEN = 2'd2,
        ST_BADSUM = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        PH_HUNT  = 7'b0000001,
        PH_ID    = 7'b0000010,
        PH_LEN   = 7'b0000100,
        PH_ERR   = 7'b0001000,
        PH_PARAM = 7'b0010000,
        PH_CHK   = 7'b0100000,
        PH_DRAIN = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic              we;
        logic [PAR_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [PAR_W-1:0]  raddr;
    } t_buf_req;

endpackage

>>> rtl/sbsp_in_if.sv
// Input channel interface carrying received bus bytes.
interface sbsp_in_if;
    import sbsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/sbsp_out_if.sv
// Output channel interface carrying parsed frame results.
interface sbsp_out_if;
    import sbsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [BYTE_W-1:0] servo_id;
    logic [BYTE_W-1:0] error_byte;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [PAR_W-1:0]  data_index;
    logic              last;

    modport source (output valid, output status, output servo_id, output error_byte,
                    output data_valid, output data_byte, output data_index,
                    output last, input ready);
    modport sink (input valid, input status, input servo_id, input error_byte,
                  input data_valid, input data_byte, input data_index,
                  input last, output ready);
endinterface

>>> rtl/sbsp_param_buf.sv
// Parameter byte buffer: one write port and one registered read port.
module sbsp_param_buf (
    input  logic                      i_clk,
    input  sbsp_pkg::t_buf_req        i_req,
    output logic [sbsp_pkg::BYTE_W-1:0] o_rdata
);
    import sbsp_pkg::*;

    logic [BYTE_W-1:0] mem [MAX_PARAMS];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/servo_bus_status_frame_parser_core.sv
// Top level of the servo bus status frame parser.
//
//   Port      Dir  Handshake    Transaction
//   i_rx      in   valid/ready  one received bus byte
//   o_res     out  valid/ready  one result item (status or parameter byte)
//   i_cfg_*   in   write enable one configuration register write
//
// A byte is taken whenever the output register is free or being emptied.
// A good frame with N parameters then drains N items, one per cycle while the output is not
// stalled, after the first registered read from the parameter memory's one read port.
// No bytes are accepted while a frame drains, and a stalled output holds off the input.
// Reset is synchronous; the parameter memory is not cleared and needs no clearing pass.
module servo_bus_status_frame_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sbsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbsp_in_if.sink                         i_rx,
    sbsp_out_if.source                      o_res
);
    import sbsp_pkg::*;

    `include "servo_bus_status_frame_parser_core_assert.svh"

    logic [BYTE_W-1:0] r_scan_limit;
    logic [LEN_W-1:0]  r_max_length;

    t_phase            r_phase,        n_phase;
    logic [1:0]        r_header_run,   n_header_run;
    logic [BYTE_W-1:0] r_scan_count,   n_scan_count;
    logic [BYTE_W-1:0] r_frame_id,     n_frame_id;
    logic [LEN_W-1:0]  r_frame_length, n_frame_length;
    logic [BYTE_W-1:0] r_frame_error,  n_frame_error;
    logic [BYTE_W-1:0] r_running_sum,  n_running_sum;
    logic [PAR_W-1:0]  r_param_count,  n_param_count;
    logic [PAR_W-1:0]  r_rd_idx,       n_rd_idx;
    logic              r_rd_pend,      n_rd_pend;

    logic              r_out_valid,    n_out_valid;
    t_status           r_out_status,   n_out_status;
    logic [BYTE_W-1:0] r_out_id,       n_out_id;
    logic [BYTE_W-1:0] r_out_err,      n_out_err;
    logic              r_out_dv,       n_out_dv;
    logic [BYTE_W-1:0] r_out_byte,     n_out_byte;
    logic [PAR_W-1:0]  r_out_idx,      n_out_idx;
    logic              r_out_last,     n_out_last;

    t_buf_req          buf_req;
    logic [BYTE_W-1:0] buf_rdata;

    logic              out_free;
    logic              in_accept;
    logic              drain_load;
    logic              drain_last;
    logic [BYTE_W-1:0] rx_b;
    logic [BYTE_W-1:0] scan_inc;
    logic [1:0]        run_inc;
    logic [PAR_W-1:0]  count_inc;
    logic              emit;
    t_status           emit_status;

    sbsp_param_buf u_param_buf (
        .i_clk   (i_clk),
        .i_req   (buf_req),
        .o_rdata (buf_rdata)
    );

    assign out_free   = !r_out_valid || o_res.ready;
    assign i_rx.ready = (r_phase != PH_DRAIN) && out_free;
    assign in_accept  = i_rx.valid && i_rx.ready;
    assign rx_b       = i_rx.rx_byte;
    assign drain_load = (r_phase == PH_DRAIN) && r_rd_pend && out_free;
    assign drain_last = (r_rd_idx + 6'd1) == r_param_count;
    assign scan_inc   = (r_scan_count != SCAN_MAX) ? r_scan_count + 8'd1 : r_scan_count;
    assign run_inc    = (r_header_run == 2'd0) ? 2'd1 : 2'd2;
    assign count_inc  = r_param_count + 6'd1;

    always_comb begin
        n_phase        = r_phase;
        n_header_run   = r_header_run;
        n_scan_count   = r_scan_count;
        n_frame_id     = r_frame_id;
        n_frame_length = r_frame_length;
        n_frame_error  = r_frame_error;
        n_running_sum  = r_running_sum;
        n_param_count  = r_param_count;
        n_rd_idx       = r_rd_idx;
        n_rd_pend      = r_rd_pend;
        emit           = 1'b0;
        emit_status    = ST_OK;
        buf_req        = '0;
        buf_req.waddr  = r_param_count;
        buf_req.wdata  = rx_b;
        buf_req.raddr  = r_rd_idx;

        if (in_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    n_scan_count = scan_inc;
                    n_header_run = (rx_b == HDR_BYTE) ? run_inc : 2'd0;
                    if (n_header_run == 2'd2) begin
                        n_phase      = PH_ID;
                        n_header_run = 2'd0;
                        n_scan_count = '0;
                    end else if (scan_inc >= r_scan_limit) begin
                        n_frame_id    = '0;
                        n_frame_error = '0;
                        emit          = 1'b1;
                        emit_status   = ST_NOHDR;
                        n_header_run  = 2'd0;
                        n_scan_count  = '0;
                    end
                end
                PH_ID: begin
                    n_frame_id = rx_b;
                    n_phase    = PH_LEN;
                end
                PH_LEN: begin
                    if (rx_b >= MIN_LENGTH && rx_b <= {2'b00, r_max_length}
                            && rx_b <= MAX_FRAME_LEN) begin
                        n_frame_length = rx_b[LEN_W-1:0];
                    end else begin
                        n_frame_length = '0;
                    end
                    n_running_sum = r_frame_id + rx_b;
                    n_phase       = PH_ERR;
                end
                PH_ERR: begin
                    n_frame_error = rx_b;
                    n_running_sum = r_running_sum + rx_b;
                    n_param_count = '0;
                    if (r_frame_length < LEN_W'(MIN_LENGTH)) begin
                        emit        = 1'b1;
                        emit_status = ST_BADLEN;
                        n_phase     = PH_HUNT;
                        n_header_run = 2'd0;
                        n_scan_count = '0;
                    end else if (r_frame_length == LEN_W'(MIN_LENGTH)) begin
                        n_phase = PH_CHK;
                    end else begin
                        n_phase = PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    buf_req.we    = 1'b1;
                    n_param_count = count_inc;
                    n_running_sum = r_running_sum + rx_b;
                    if (({1'b0, count_inc} + 7'd2) >= {1'b0, r_frame_length}) begin
                        n_phase = PH_CHK;
                    end
                end
                PH_CHK: begin
                    n_header_run = 2'd0;
                    n_scan_count = '0;
                    if (rx_b != ~r_running_sum) begin
                        emit        = 1'b1;
                        emit_status = ST_BADSUM;
                        n_phase     = PH_HUNT;
                    end else if (r_param_count == '0) begin
                        emit        = 1'b1;
                        emit_status = ST_OK;
                        n_phase     = PH_HUNT;
                    end else begin
                        n_phase   = PH_DRAIN;
                        n_rd_idx  = '0;
                        n_rd_pend = 1'b0;
                    end
                end
                default: begin
                    n_phase      = PH_HUNT;
                    n_header_run = 2'd0;
                    n_scan_count = '0;
                end
            endcase
        end else if (r_phase == PH_DRAIN) begin
            if (!r_rd_pend) begin
                buf_req.re = 1'b1;
                n_rd_pend  = 1'b1;
            end else if (drain_load) begin
                n_rd_idx = r_rd_idx + 6'd1;
                if (drain_last) begin
                    n_rd_pend = 1'b0;
                    n_phase   = PH_HUNT;
                end else begin
                    buf_req.re    = 1'b1;
                    buf_req.raddr = r_rd_idx + 6'd1;
                    n_rd_pend     = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_err    = r_out_err;
        n_out_dv     = r_out_dv;
        n_out_byte   = r_out_byte;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = emit_status;
            n_out_id     = n_frame_id;
            n_out_err    = n_frame_error;
            n_out_dv     = 1'b0;
            n_out_byte   = '0;
            n_out_idx    = '0;
            n_out_last   = 1'b1;
        end else if (drain_load) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            n_out_id     = r_frame_id;
            n_out_err    = r_frame_error;
            n_out_dv     = 1'b1;
            n_out_byte   = buf_rdata;
            n_out_idx    = r_rd_idx;
            n_out_last   = drain_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= SCAN_LIMIT_RST;
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCAN_LIMIT: r_scan_limit <= i_cfg_data;
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_header_run   <= '0;
            r_scan_count   <= '0;
            r_frame_id     <= '0;
            r_frame_length <= '0;
            r_frame_error  <= '0;
            r_running_sum  <= '0;
            r_param_count  <= '0;
            r_rd_idx       <= '0;
            r_rd_pend      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_header_run   <= n_header_run;
            r_scan_count   <= n_scan_count;
            r_frame_id     <= n_frame_id;
            r_frame_length <= n_frame_length;
            r_frame_error  <= n_frame_error;
            r_running_sum  <= n_running_sum;
            r_param_count  <= n_param_count;
            r_rd_idx       <= n_rd_idx;
            r_rd_pend      <= n_rd_pend;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_err    <= n_out_err;
        r_out_dv     <= n_out_dv;
        r_out_byte   <= n_out_byte;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.servo_id   = r_out_id;
    assign o_res.error_byte = r_out_err;
    assign o_res.data_valid = r_out_dv;
    assign o_res.data_byte  = r_out_byte;
    assign o_res.data_index = r_out_idx;
    assign o_res.last       = r_out_last;

    `SBSP_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_param_count <= PAR_W'(MAX_PARAMS))
    `SBSP_ASSERT_IMPL(a_pend_in_drain, i_clk, i_rst_n, r_rd_pend, r_phase == PH_DRAIN)
    `SBSP_ASSERT_IMPL(a_drain_idx, i_clk, i_rst_n, r_phase == PH_DRAIN, r_rd_idx < r_param_count)
    `SBSP_ASSERT_NEXT(a_drain_end, i_clk, i_rst_n, drain_load && drain_last, r_phase == PH_HUNT && o_res.last)
endmodule

>>> sim/frame_check_pkg.sv
// Scoreboard class that predicts and checks the parser's result transactions.
package frame_check_pkg;
    import sbsp_pkg::*;

    typedef struct {
        t_status           status;
        logic [BYTE_W-1:0] servo_id;
        logic [BYTE_W-1:0] error_byte;
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic [PAR_W-1:0]  data_index;
        logic              last;
    } t_frame_result;

    class frame_outcome_board;
        logic [BYTE_W-1:0] scan_limit;
        logic [LEN_W-1:0]  max_length;
        t_phase            phase;
        int                header_run;
        logic [BYTE_W-1:0] scan_count;
        logic [BYTE_W-1:0] frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] frame_error;
        logic [BYTE_W-1:0] running_sum;
        int                param_count;
        logic [BYTE_W-1:0] param_store [MAX_PARAMS];
        t_frame_result     awaited [$];
        int                mismatches;
        int                results_seen;
        int                outcome_count [4];

        function new();
            scan_limit   = SCAN_LIMIT_RST;
            max_length   = MAX_LENGTH_RST;
            frame_id     = '0;
            frame_length = '0;
            frame_error  = '0;
            running_sum  = '0;
            param_count  = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (outcome_count[k]) outcome_count[k] = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            phase      = PH_HUNT;
            header_run = 0;
            scan_count = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_SCAN_LIMIT) begin
                scan_limit = value;
            end else if (idx == CFG_MAX_LENGTH) begin
                max_length = value[LEN_W-1:0];
            end
        endfunction

        function void expect_item(t_status st, logic dv, logic [BYTE_W-1:0] db,
                                  logic [PAR_W-1:0] di, logic lst);
            t_frame_result item;
            item.status     = st;
            item.servo_id   = frame_id;
            item.error_byte = frame_error;
            item.data_valid = dv;
            item.data_byte  = db;
            item.data_index = di;
            item.last       = lst;
            awaited = {awaited, item};
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void take_byte(logic [BYTE_W-1:0] rx);
            case (phase)
                PH_HUNT: begin
                    if (scan_count != SCAN_MAX) scan_count++;
                    if (rx == HDR_BYTE) begin
                        header_run = (header_run < 2) ? header_run + 1 : 2;
                    end else begin
                        header_run = 0;
                    end
                    if (header_run >= 2) begin
                        phase      = PH_ID;
                        header_run = 0;
                        scan_count = '0;
                    end else if (scan_count >= scan_limit) begin
                        frame_id    = '0;
                        frame_error = '0;
                        expect_item(ST_NOHDR, 1'b0, '0, '0, 1'b1);
                        restart_hunt();
                    end
                end
                PH_ID: begin
                    frame_id = rx;
                    phase    = PH_LEN;
                end
                PH_LEN: begin
                    if (rx >= MIN_LENGTH && rx <= {2'b00, max_length} && rx <= MAX_FRAME_LEN) begin
                        frame_length = rx[LEN_W-1:0];
                    end else begin
                        frame_length = '0;
                    end
                    running_sum = frame_id + rx;
                    phase       = PH_ERR;
                end
                PH_ERR: begin
                    frame_error = rx;
                    running_sum = running_sum + rx;
                    param_count = 0;
                    if (frame_length < 2) begin
                        expect_item(ST_BADLEN, 1'b0, '0, '0, 1'b1);
                        restart_hunt();
                    end else begin
                        phase = (frame_length == 2) ? PH_CHK : PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    if (param_count < MAX_PARAMS) param_store[param_count] = rx;
                    param_count++;
                    running_sum = running_sum + rx;
                    if (param_count + 2 >= frame_length) phase = PH_CHK;
                end
                PH_CHK: begin
                    if (rx != ~running_sum) begin
                        expect_item(ST_BADSUM, 1'b0, '0, '0, 1'b1);
                    end else if (param_count == 0) begin
                        expect_item(ST_OK, 1'b0, '0, '0, 1'b1);
                    end else begin
                        if (param_count > MAX_PARAMS) param_count = MAX_PARAMS;
                        for (int k = 0; k < param_count; k++) begin
                            expect_item(ST_OK, 1'b1, param_store[k], PAR_W'(k),
                                        k + 1 == param_count);
                        end
                    end
                    restart_hunt();
                end
                default: begin
                    restart_hunt();
                end
            endcase
        endfunction

        task report(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            mismatches++;
            if (mismatches <= 30) begin
                $display("Mismatch in result %0d, %s: got %h, wanted %h",
                         results_seen, what, got, want);
            end
        endtask

        task check_item(logic [1:0] st, logic [BYTE_W-1:0] id, logic [BYTE_W-1:0] err,
                        logic dv, logic [BYTE_W-1:0] db, logic [PAR_W-1:0] di, logic lst);
            t_frame_result want;
            results_seen++;
            if (awaited.size() == 0) begin
                report("result with none awaited, status", BYTE_W'(st), '0);
                return;
            end
            want = awaited.pop_front();
            if (want.last) outcome_count[want.status]++;
            if (st !== want.status) report("status", BYTE_W'(st), BYTE_W'(want.status));
            if (id !== want.servo_id) report("servo_id", id, want.servo_id);
            if (err !== want.error_byte) report("error_byte", err, want.error_byte);
            if (dv !== want.data_valid) report("data_valid", BYTE_W'(dv), BYTE_W'(want.data_valid));
            if (db !== want.data_byte) report("data_byte", db, want.data_byte);
            if (di !== want.data_index) report("data_index", BYTE_W'(di), BYTE_W'(want.data_index));
            if (lst !== want.last) report("last", BYTE_W'(lst), BYTE_W'(want.last));
        endtask
    endclass

endpackage

>>> sim/tb_top.sv
// Testbench top that drives the frame parser with bus bytes and checks every result.
module tb_top;
    import sbsp_pkg::*;
    import frame_check_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sbsp_in_if  rx_if ();
    sbsp_out_if res_if ();

    frame_outcome_board board = new();

    int         stall_mode;
    logic       hold_toggle;
    bit         sender_gaps;
    int         burst_left;
    int         bytes_sent;
    logic [5:0] max_len_now;

    servo_bus_status_frame_parser_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                board.check_item(res_if.status, res_if.servo_id, res_if.error_byte,
                                 res_if.data_valid, res_if.data_byte, res_if.data_index,
                                 res_if.last);
            end
            if (rx_if.valid && rx_if.ready) board.take_byte(rx_if.rx_byte);
        end
    end

    // The receiver stalls on its own pattern and honors a long hold-off on request.
    initial begin
        int   rcv_cycle;
        int   hold_left;
        logic hold_seen;
        rcv_cycle    = 0;
        hold_left    = 0;
        hold_seen    = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rcv_cycle++;
            if (hold_toggle !== hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    2: res_if.ready <= ((rcv_cycle % 7) >= 3);
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        bytes_sent++;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= value;
        do @(posedge i_clk); while (!rx_if.ready);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (board.outstanding() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        board.set_register(idx, value);
        if (idx == CFG_MAX_LENGTH) max_len_now = value[5:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input logic [7:0] err, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] param;
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(id);
        send_byte(len);
        send_byte(err);
        if (len < MIN_LENGTH || len > max_len_now || len > MAX_FRAME_LEN) return;
        sum = id + len + err;
        for (int k = 0; k < len - 2; k++) begin
            param = $urandom_range(0, 255);
            sum   = sum + param;
            send_byte(param);
        end
        send_byte(bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    endtask

    task automatic send_random_frame();
        int         pick;
        int         top;
        int         floor_bad;
        logic [7:0] id;
        logic [7:0] len;
        pick      = $urandom_range(0, 99);
        top       = (max_len_now > MAX_FRAME_LEN) ? MAX_FRAME_LEN : max_len_now;
        floor_bad = top + 1;
        id        = ($urandom_range(0, 9) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0 || top < 10) begin
            len = (top >= 2) ? 8'($urandom_range(2, top)) : MIN_LENGTH;
        end else begin
            len = 8'($urandom_range(2, 10));
        end
        if (pick < 70) begin
            send_frame(id, len, 8'($urandom_range(0, 255)), pick >= 60);
        end else if (pick < 80) begin
            case ($urandom_range(0, 2))
                0: len = 8'($urandom_range(0, 1));
                1: len = 8'(floor_bad);
                default: len = 8'($urandom_range(floor_bad, 255));
            endcase
            send_frame(id, len, 8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) begin
                send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255)));
            end
        end else begin
            send_byte(HDR_BYTE);
            send_byte(HDR_BYTE);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int            start;
        logic [7:0]    scan_set;
        logic [7:0]    len_set;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        hold_toggle   = 1'b0;
        stall_mode    = 1;
        sender_gaps   = 1'b1;
        burst_left    = 0;
        bytes_sent    = 0;
        max_len_now   = MAX_LENGTH_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_frame(8'h01, 8'd2, 8'h00, 1'b0);
        send_frame(8'hFE, 8'd4, 8'hFF, 1'b0);
        send_frame(8'h7F, 8'd3, 8'h80, 1'b1);
        send_frame(8'h00, 8'd1, 8'h00, 1'b0);
        send_frame(8'h55, 8'd0, 8'h01, 1'b0);
        send_frame(8'hAA, 8'd51, 8'h02, 1'b0);
        send_frame(8'hFF, 8'd2, 8'h40, 1'b0);
        send_frame(8'h3C, 8'd50, 8'h00, 1'b0);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'h10);
        wait_drained();
        write_reg(CFG_MAX_LENGTH, 8'd3);
        send_byte(8'd4);
        send_byte(8'h00);
        send_frame(8'h11, 8'd3, 8'h00, 1'b0);
        wait_drained();
        write_reg(CFG_MAX_LENGTH, 8'd0);
        send_frame(8'h12, 8'd2, 8'h00, 1'b0);
        wait_drained();
        write_reg(CFG_MAX_LENGTH, 8'(MAX_LENGTH_RST));
        write_reg(CFG_SCAN_LIMIT, 8'd2);
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(8'h20, 8'd2, 8'h01, 1'b0);
        wait_drained();
        write_reg(CFG_SCAN_LIMIT, 8'd1);
        send_byte(8'h12);
        send_byte(HDR_BYTE);
        wait_drained();
        write_reg(CFG_SCAN_LIMIT, 8'd0);
        send_byte(8'h56);

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin scan_set = 8'd50; len_set = 8'd50; stall_mode = 1; sender_gaps = 1; end
                1: begin scan_set = 8'd255; len_set = 8'd63; stall_mode = 0; sender_gaps = 0; end
                2: begin scan_set = 8'd2; len_set = 8'd50; stall_mode = 2; sender_gaps = 1; end
                3: begin
                    scan_set    = 8'($urandom_range(3, 40));
                    len_set     = 8'($urandom_range(2, 50));
                    stall_mode  = 3;
                    sender_gaps = 1;
                end
                4: begin scan_set = 8'd20; len_set = 8'd2; stall_mode = 1; sender_gaps = 0; end
                default: begin
                    scan_set    = SCAN_LIMIT_RST;
                    len_set     = 8'(MAX_LENGTH_RST);
                    stall_mode  = 1;
                    sender_gaps = 1;
                end
            endcase
            write_reg(CFG_SCAN_LIMIT, scan_set);
            write_reg(CFG_MAX_LENGTH, len_set);
            start = bytes_sent;
            if (ph == 2) begin
                hold_toggle <= ~hold_toggle;
                send_frame(8'($urandom_range(0, 255)), 8'd40, 8'($urandom_range(0, 255)), 1'b0);
            end
            while (bytes_sent - start < 36) send_random_frame();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d bus bytes and %0d result transactions over several register settings.",
                 bytes_sent, board.results_seen);
        $display("Outcomes: %0d ok, %0d no header, %0d bad length, %0d bad checksum.",
                 board.outcome_count[ST_OK], board.outcome_count[ST_NOHDR],
                 board.outcome_count[ST_BADLEN], board.outcome_count[ST_BADSUM]);
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
